// ===== src/rksm_pkg.sv =====
package rksm_pkg;

    localparam int PatMax = 32;
    localparam int IdxW   = $clog2(PatMax);
    localparam int LenW   = 6;
    localparam int ModW   = 16;
    localparam int PosW   = 32;
    localparam logic [4:0] Radix = 5'd20;

    localparam logic CfgLength  = 1'b0;
    localparam logic CfgModulus = 1'b1;

    localparam logic ReqPattern = 1'b0;
    localparam logic ReqText    = 1'b1;

    // request to the modular reduction unit: (a * b + c) mod q, a below q
    typedef struct packed {
        logic            start;
        logic [ModW-1:0] a;
        logic [ModW-1:0] b;
        logic [ModW-1:0] c;
    } mod_req_t;

    typedef struct packed {
        logic            done;
        logic [ModW-1:0] r;
    } mod_rsp_t;

endpackage

// ===== src/rksm_if.sv =====
interface rksm_req_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;
    logic [4:0] pattern_index;
    logic       new_text;
    modport source (output valid, req_type, data_byte, pattern_index, new_text, input ready);
    modport sink (input valid, req_type, data_byte, pattern_index, new_text, output ready);
endinterface

interface rksm_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] match_start;
    modport source (output valid, match_start, input ready);
    modport sink (input valid, match_start, output ready);
endinterface

interface rksm_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== src/rksm_modmul.sv =====
// Computes (a*b + c) mod q for a below q, one bit of b and c per cycle, MSB first.
module rksm_modmul
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [rksm_pkg::ModW-1:0] q,
    input  rksm_pkg::mod_req_t        req,
    output rksm_pkg::mod_rsp_t        rsp
);
    localparam int W  = rksm_pkg::ModW;
    localparam int CW = $clog2(W);

    logic [W-1:0]  a_reg;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  c_reg;
    logic [W-1:0]  acc_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W+1:0] sum;
    logic [W-1:0] acc_next;

    always_comb
    begin
        // 2*acc + a + 1 stays below 4q, so two conditional subtractions suffice
        sum = {1'b0, acc_reg, 1'b0}
            + (b_reg[W-1] ? {2'b00, a_reg} : '0)
            + {{(W+1){1'b0}}, c_reg[W-1]};
        if (sum >= {1'b0, q, 1'b0}) sum = sum - {1'b0, q, 1'b0};
        if (sum >= {2'b00, q}) sum = sum - {2'b00, q};
        acc_next = sum[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            c_reg    <= '0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= 1'b1;
                done_reg <= 1'b0;
                a_reg    <= req.a;
                b_reg    <= req.b;
                c_reg    <= req.c;
                acc_reg  <= '0;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                acc_reg <= acc_next;
                b_reg   <= {b_reg[W-2:0], 1'b0};
                c_reg   <= {c_reg[W-2:0], 1'b0};
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(W-1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.r    = acc_reg;
endmodule

// ===== src/rabin_karp_stream_matcher_top.sv =====
// Rabin-Karp stream matcher, radix 20, modulus q. Load pattern bytes by index
// with req_type 0; loading index m-1 computes the pattern hash and 20^(m-1) mod q
// from the stored bytes and the current registers, keeping the block busy until
// both are done. Stream text with req_type 1, new_text marking the first byte of
// a text. Every modular product and reduction goes through one bit-serial
// (a*b+c) mod q unit, and the subtraction of the oldest byte is done beside it:
// a text byte keeps the block busy for one pass while the window fills and three
// passes once m bytes are held. When the hashes agree on a full window, the byte
// check compares the pattern and window memories byte by byte, and a confirmed
// match goes through S_OUT to the output register; the block stalls in S_OUT
// while an earlier match still waits there untaken. One item is processed at a
// time. A register write restarts the text search.
module rabin_karp_stream_matcher_top
(
    input logic        clk,
    input logic        rst_n,
    rksm_req_if.sink   req,
    rksm_res_if.source res,
    rksm_cfg_if.sink   cfg
);
    localparam int W  = rksm_pkg::ModW;
    localparam int IW = rksm_pkg::IdxW;
    localparam int LW = rksm_pkg::LenW;
    localparam int PW = rksm_pkg::PosW;

    typedef enum logic [4:0] {
        S_IDLE, S_PW_INIT, S_PW_WAIT, S_PW_MUL, S_PH_RD, S_PH_MUL, S_PH_WAIT,
        S_RP, S_RP_WAIT, S_RD_OLD, S_DROP, S_DROP_WAIT, S_ADD, S_ADD_WAIT,
        S_CMP_RD, S_CMP, S_OUT
    } state_t;

    state_t state_reg;
    logic [LW-1:0] m_cfg_reg;
    logic [W-1:0]  q_cfg_reg;
    logic [W-1:0]  phash_reg, thash_reg, rpow_reg, acc_reg, t_reg;
    logic [PW-1:0] seen_reg, match_reg;
    logic [IW:0]   fill_reg, i_reg;
    logic [IW-1:0] head_reg;
    logic [7:0]    byte_reg;
    logic          res_valid_reg;

    // pattern store and ring-buffer window memories
    logic [7:0] pmem [rksm_pkg::PatMax];
    logic [7:0] wmem [rksm_pkg::PatMax];
    logic [7:0] prd_reg, wrd_reg;
    logic          pwe, wwe;
    logic [IW-1:0] pwa, wwa, pra, wra;
    logic [7:0]    pwd, wwd;

    logic [IW:0]  m_eff;
    logic [W-1:0] q_eff;
    logic         req_acc, cfg_acc, res_load, full_next;
    rksm_pkg::mod_req_t mreq;
    rksm_pkg::mod_rsp_t mrsp;

    logic [IW-1:0] widx, wpos;
    logic [W:0]    sub;

    always_comb
    begin
        m_eff = (m_cfg_reg == '0) ? (IW+1)'(1)
              : (m_cfg_reg > LW'(rksm_pkg::PatMax)) ? (IW+1)'(rksm_pkg::PatMax)
              : m_cfg_reg;
        q_eff = (q_cfg_reg < W'(2)) ? W'(2) : q_cfg_reg;
    end

    rksm_modmul u_mod (.clk(clk), .rst_n(rst_n), .q(q_eff), .req(mreq), .rsp(mrsp));

    always_ff @(posedge clk)
    begin
        if (pwe) pmem[pwa] <= pwd;
        if (wwe) wmem[wwa] <= wwd;
        prd_reg <= pmem[pra];
        wrd_reg <= wmem[wra];
    end

    assign req.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg.ready = (state_reg == S_IDLE);
    assign res.valid = res_valid_reg;
    assign res.match_start = match_reg;

    assign req_acc   = req.valid && req.ready;
    assign cfg_acc   = cfg.valid && cfg.ready;
    assign res_load  = (state_reg == S_OUT) && (!res_valid_reg || res.ready);
    assign full_next = (fill_reg + (IW+1)'(1)) >= m_eff;

    always_comb
    begin
        widx = head_reg + i_reg[IW-1:0];
        // newest byte goes one past the window; once full the oldest slot drops out
        wpos = (fill_reg >= m_eff) ? head_reg + m_eff[IW-1:0]
                                   : head_reg + fill_reg[IW-1:0];
        sub  = {1'b0, t_reg} + {1'b0, q_eff} - {1'b0, mrsp.r};
        if (sub >= {1'b0, q_eff}) sub = sub - {1'b0, q_eff};
        pwe = 1'b0; pwa = req.pattern_index; pwd = req.data_byte;
        wwe = 1'b0; wwa = wpos; wwd = byte_reg;
        pra = i_reg[IW-1:0]; wra = widx;
        mreq = '0;
        unique case (state_reg)
            S_IDLE: pwe = req_acc && req.req_type == rksm_pkg::ReqPattern;
            S_PW_INIT:
            begin
                mreq.start = 1'b1;
                mreq.c     = W'(1);
            end
            S_PW_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = acc_reg;
                mreq.b     = W'(rksm_pkg::Radix);
            end
            S_PH_MUL:
            begin
                mreq.start = 1'b1;
                mreq.a     = t_reg;
                mreq.b     = W'(rksm_pkg::Radix);
                mreq.c     = W'(prd_reg);
            end
            S_RP:
            begin
                mreq.start = 1'b1;
                mreq.c     = rpow_reg;
            end
            S_RD_OLD: wra = head_reg;
            S_DROP:
            begin
                mreq.start = 1'b1;
                mreq.a     = acc_reg;
                mreq.b     = W'(wrd_reg);
            end
            S_ADD:
            begin
                mreq.start = 1'b1;
                mreq.a     = t_reg;
                mreq.b     = W'(rksm_pkg::Radix);
                mreq.c     = W'(byte_reg);
            end
            S_ADD_WAIT: wwe = mrsp.done;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            m_cfg_reg     <= LW'(1);
            q_cfg_reg     <= W'(13);
            phash_reg     <= '0;
            thash_reg     <= '0;
            rpow_reg      <= W'(1);
            acc_reg       <= '0;
            t_reg         <= '0;
            seen_reg      <= '0;
            match_reg     <= '0;
            fill_reg      <= '0;
            head_reg      <= '0;
            i_reg         <= '0;
            byte_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (res_load) res_valid_reg <= 1'b1;
            else if (res.valid && res.ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_acc)
                    begin
                        if (cfg.index == rksm_pkg::CfgLength) m_cfg_reg <= cfg.data[LW-1:0];
                        else q_cfg_reg <= cfg.data;
                        thash_reg <= '0; seen_reg <= '0; fill_reg <= '0; head_reg <= '0;
                    end
                    else if (req_acc)
                    begin
                        byte_reg <= req.data_byte;
                        if (req.req_type == rksm_pkg::ReqPattern)
                        begin
                            if ({1'b0, req.pattern_index} == m_eff - (IW+1)'(1))
                            begin
                                i_reg <= '0;
                                state_reg <= S_PW_INIT;
                            end
                        end
                        else if (req.new_text)
                        begin
                            // restart: window contents beyond fill are never read
                            thash_reg <= '0; seen_reg <= '0; fill_reg <= '0; head_reg <= '0;
                            t_reg <= '0;
                            state_reg <= S_ADD;
                        end
                        else
                        begin
                            t_reg <= thash_reg;
                            state_reg <= (fill_reg >= m_eff) ? S_RP : S_ADD;
                        end
                    end
                end
                // radix power: 1 mod q, then m-1 multiplications by 20
                S_PW_INIT: state_reg <= S_PW_WAIT;
                S_PW_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        acc_reg <= mrsp.r;
                        if (i_reg == m_eff - (IW+1)'(1))
                        begin
                            rpow_reg  <= mrsp.r;
                            t_reg     <= '0;
                            i_reg     <= '0;
                            state_reg <= S_PH_RD;
                        end
                        else
                        begin
                            state_reg <= S_PW_MUL;
                        end
                    end
                end
                S_PW_MUL:
                begin
                    i_reg <= i_reg + (IW+1)'(1);
                    state_reg <= S_PW_WAIT;
                end
                // pattern hash: fold in one stored byte per pass
                S_PH_RD: state_reg <= S_PH_MUL;
                S_PH_MUL: state_reg <= S_PH_WAIT;
                S_PH_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        t_reg <= mrsp.r;
                        if (i_reg == m_eff - (IW+1)'(1))
                        begin
                            phash_reg <= mrsp.r;
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            i_reg <= i_reg + (IW+1)'(1);
                            state_reg <= S_PH_RD;
                        end
                    end
                end
                // drop the oldest byte: reduce the radix power, then scale it
                S_RP: state_reg <= S_RP_WAIT;
                S_RP_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        acc_reg <= mrsp.r;
                        state_reg <= S_RD_OLD;
                    end
                end
                S_RD_OLD: state_reg <= S_DROP;
                S_DROP: state_reg <= S_DROP_WAIT;
                S_DROP_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        t_reg <= sub[W-1:0];
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: state_reg <= S_ADD_WAIT;
                S_ADD_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        thash_reg <= mrsp.r;
                        seen_reg  <= seen_reg + PW'(1);
                        if (fill_reg >= m_eff) head_reg <= head_reg + IW'(1);
                        else fill_reg <= fill_reg + (IW+1)'(1);
                        i_reg <= '0;
                        state_reg <= (full_next && mrsp.r == phash_reg) ? S_CMP_RD : S_IDLE;
                    end
                end
                S_CMP_RD: state_reg <= S_CMP;
                S_CMP:
                begin
                    if (prd_reg != wrd_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else if (i_reg == m_eff - (IW+1)'(1))
                    begin
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        i_reg <= i_reg + (IW+1)'(1);
                        state_reg <= S_CMP_RD;
                    end
                end
                // hold until the output register is free
                S_OUT:
                begin
                    if (res_load)
                    begin
                        match_reg <= seen_reg - PW'(m_eff);
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== verif/tb_rabin_karp_stream_matcher_top.sv =====
module tb_rabin_karp_stream_matcher_top;

    class match_scoreboard;
        logic [7:0]  pat [rksm_pkg::PatMax];
        logic [7:0]  win [rksm_pkg::PatMax];
        logic [15:0] pat_hash;
        logic [15:0] txt_hash;
        logic [15:0] rad_pow;
        logic [31:0] seen;
        int unsigned fill;
        logic [5:0]  len_reg;
        logic [15:0] mod_reg;
        logic [31:0] pending [$];
        int          errors;

        function new();
            for (int i = 0; i < rksm_pkg::PatMax; i++)
            begin
                pat[i] = 8'd0;
            end
            pat_hash = 16'd0;
            rad_pow  = 16'd1;
            len_reg  = 6'd1;
            mod_reg  = 16'd13;
            errors   = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < rksm_pkg::PatMax; i++)
            begin
                win[i] = 8'd0;
            end
            txt_hash = 16'd0;
            seen     = 32'd0;
            fill     = 0;
        endfunction

        function int unsigned eff_len();
            if (len_reg < 1)
            begin
                return 1;
            end
            if (len_reg > rksm_pkg::PatMax)
            begin
                return rksm_pkg::PatMax;
            end
            return len_reg;
        endfunction

        function int unsigned eff_mod();
            return (mod_reg < 2) ? 2 : mod_reg;
        endfunction

        function void write_reg(logic idx, logic [15:0] val);
            if (idx == rksm_pkg::CfgLength)
            begin
                len_reg = val[5:0];
            end
            else
            begin
                mod_reg = val;
            end
            restart();
        endfunction

        function void note_item(logic kind, logic [7:0] b, logic [4:0] idx, logic fresh);
            int unsigned m;
            int unsigned q;
            int unsigned t;
            int unsigned h;
            int unsigned p;
            int unsigned drop;
            bit ok;
            m = eff_len();
            q = eff_mod();
            if (kind == rksm_pkg::ReqPattern)
            begin
                pat[idx] = b;
                if (idx == m - 1)
                begin
                    h = 1 % q;
                    p = 0;
                    for (int i = 0; i + 1 < m; i++)
                    begin
                        h = (h * 20) % q;
                    end
                    for (int i = 0; i < m; i++)
                    begin
                        p = (p * 20 + pat[i]) % q;
                    end
                    rad_pow  = 16'(h);
                    pat_hash = 16'(p);
                end
                return;
            end
            if (fresh)
            begin
                restart();
            end
            t = txt_hash % q;
            if (fill >= m)
            begin
                drop = (win[0] * (rad_pow % q)) % q;
                t = (t + q - drop) % q;
                for (int i = 0; i + 1 < m; i++)
                begin
                    win[i] = win[i+1];
                end
            end
            else
            begin
                fill++;
            end
            t = (t * 20 + b) % q;
            txt_hash = 16'(t);
            win[fill-1] = b;
            seen++;
            if (fill < m || t != pat_hash)
            begin
                return;
            end
            ok = 1;
            for (int k = 0; k < m; k++)
            begin
                if (win[k] != pat[k])
                begin
                    ok = 0;
                end
            end
            if (ok)
            begin
                pending.push_back(seen - m);
            end
        endfunction

        function void check_match(logic [31:0] got);
            logic [31:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: match_start expected none actual %0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (want !== got)
            begin
                $display("%0t: match_start expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    rksm_req_if req ();
    rksm_res_if res ();
    rksm_cfg_if cfg ();

    rabin_karp_stream_matcher_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res),
        .cfg   (cfg)
    );

    match_scoreboard sb;
    int  send_idle;
    int  recv_stall;
    bit  hold_off;
    logic [7:0] cur_pat [rksm_pkg::PatMax];
    int unsigned cur_m;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // receiver: decide ready at the falling edge, check at the rising edge
    always @(negedge clk)
    begin
        if (hold_off)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            res.ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            sb.check_match(res.match_start);
        end
    end

    // valid stays high after a beat so that the next beat can follow at once
    task automatic send_item(logic kind, logic [7:0] b, logic [4:0] idx, logic fresh);
        while ($urandom_range(99) < send_idle)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.req_type      <= kind;
        req.data_byte     <= b;
        req.pattern_index <= idx;
        req.new_text      <= fresh;
        do
        begin
            @(posedge clk);
        end
        while (!req.ready);
        sb.note_item(kind, b, idx, fresh);
        @(negedge clk);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3000)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        drain();
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do
        begin
            @(posedge clk);
        end
        while (!cfg.ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // load a pattern of length m, last index loaded last so the hash is current
    task automatic load_pattern(int unsigned m, bit low_alpha);
        for (int i = 0; i < m; i++)
        begin
            cur_pat[i] = low_alpha ? 8'($urandom_range(1)) : 8'($urandom);
            send_item(rksm_pkg::ReqPattern, cur_pat[i], 5'(i), 1'($urandom));
        end
        cur_m = m;
    endtask

    task automatic random_text(int n, bit low_alpha);
        logic [7:0] b;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(9);
            if (k < 2)
            begin
                // embed the pattern
                for (int j = 0; j < cur_m; j++)
                begin
                    send_item(rksm_pkg::ReqText, cur_pat[j], 5'($urandom), 1'b0);
                end
                i += cur_m;
            end
            else
            begin
                b = low_alpha ? 8'($urandom_range(1)) : 8'($urandom);
                send_item(rksm_pkg::ReqText, b, 5'($urandom), ($urandom_range(40) == 0));
            end
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.req_type = rksm_pkg::ReqPattern;
        req.data_byte = 8'd0;
        req.pattern_index = 5'd0;
        req.new_text = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = rksm_pkg::CfgLength;
        cfg.data = 16'd0;
        res.ready = 1'b0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 1'b0;
        repeat (2)
        begin
            @(negedge clk);
        end
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset settings, extremes of bytes and the m=1 pattern
        send_item(rksm_pkg::ReqPattern, 8'hFF, 5'd0, 1'b1);
        send_item(rksm_pkg::ReqText, 8'hFF, 5'd31, 1'b1);
        send_item(rksm_pkg::ReqText, 8'h00, 5'd0, 1'b0);
        send_item(rksm_pkg::ReqText, 8'hFF, 5'd0, 1'b0);
        send_item(rksm_pkg::ReqPattern, 8'h00, 5'd0, 1'b0);
        send_item(rksm_pkg::ReqText, 8'h00, 5'd0, 1'b1);
        send_item(rksm_pkg::ReqText, 8'h0D, 5'd0, 1'b0);
        // out-of-range registers: m=0 acts as 1, q=0 and 1 act as 2
        write_reg(rksm_pkg::CfgLength, 16'd0);
        write_reg(rksm_pkg::CfgModulus, 16'd0);
        send_item(rksm_pkg::ReqPattern, 8'h02, 5'd0, 1'b0);
        send_item(rksm_pkg::ReqText, 8'h02, 5'd0, 1'b0);
        send_item(rksm_pkg::ReqText, 8'h04, 5'd0, 1'b0);
        write_reg(rksm_pkg::CfgModulus, 16'd1);
        send_item(rksm_pkg::ReqText, 8'h02, 5'd0, 1'b0);
        // m beyond the store acts as the store size, q at its maximum
        write_reg(rksm_pkg::CfgLength, 16'd63);
        write_reg(rksm_pkg::CfgModulus, 16'hFFFF);
        load_pattern(32, 1'b1);
        random_text(40, 1'b1);
        // rewrite a pattern byte later: the byte check uses it, the hash does not
        send_item(rksm_pkg::ReqPattern, ~cur_pat[0], 5'd0, 1'b0);
        cur_pat[0] = ~cur_pat[0];
        random_text(40, 1'b1);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 86; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 86; end
                default: begin send_idle = 11; recv_stall = 11; end
            endcase
            write_reg(rksm_pkg::CfgLength, 16'($urandom_range(ph == 7 ? 32 : 6, 1)));
            write_reg(rksm_pkg::CfgModulus, (ph % 2) ? 16'($urandom_range(65535, 2))
                                                     : 16'($urandom_range(5, 2)));
            load_pattern(sb.eff_len(), ph < 6);
            if (ph == 4)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000)
                        begin
                            @(negedge clk);
                        end
                        hold_off = 1'b0;
                    end
                join_none
            end
            random_text(70, ph < 6);
        end
        send_idle = 0;
        recv_stall = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("tb_rabin_karp_stream_matcher_top passed");
        end
        else
        begin
            $display("tb_rabin_karp_stream_matcher_top failed");
        end
        $finish;
    end

    initial
    begin
        #8000000;
        $display("tb_rabin_karp_stream_matcher_top failed");
        $finish;
    end
endmodule

// ===== sim.f =====
src/rksm_pkg.sv
src/rksm_if.sv
src/rksm_modmul.sv
src/rabin_karp_stream_matcher_top.sv
verif/tb_rabin_karp_stream_matcher_top.sv
